// ----- rtl/core/msvg_pkg.sv -----
// ============================================================================
// msvg_pkg
// Shared constants, types and helper functions for the Mobius strip vertex
// generator.
// ============================================================================
package msvg_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
	localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
	localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;
	localparam logic [30:0]        Q28_TWO_PI  = 31'd1686629713;
	localparam logic [29:0]        Q16_TWO_PI  = 30'd411775;

	typedef enum logic [1:0] {
		REG_SEGMENT_COUNT = 2'd0,
		REG_ANGLE_STEP    = 2'd1,
		REG_EDGE_LOW      = 2'd2,
		REG_EDGE_HIGH     = 2'd3
	} reg_index_t;

	// reduced and folded angles, Q.28
	typedef struct packed {
		logic               valid;
		logic               err;
		logic signed [31:0] a_u;
		logic               neg_u;
		logic signed [31:0] a_h;
		logic               neg_h;
	} angle_t;

	// products ahead of the final rounding
	typedef struct packed {
		logic               valid;
		logic               err;
		logic signed [63:0] px_lo;
		logic signed [63:0] py_lo;
		logic signed [15:0] z_lo;
		logic signed [63:0] px_hi;
		logic signed [63:0] py_hi;
		logic signed [15:0] z_hi;
	} vert_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/mobius_strip_vertex_generator_unit.sv -----
// ============================================================================
// mobius_strip_vertex_generator_unit
// Mobius strip tessellation: one segment index in, two strip vertices out.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, segment_index) takes a segment index k.
//   Output channel (out_valid/out_ready) returns two vertices per item: the
//   low-edge vertex (is_last 0) then the high-edge vertex (is_last 1). An
//   index above the segment count or MAX_SEGMENTS gives range_error 1 with
//   zero coordinates. The user writes configuration (cfg_we, cfg_index,
//   cfg_data) only while idle; the block does not enforce it.
// Throughput: set by the output register that hands out two vertices per
//   item; the pipeline itself takes one per cycle while not stalled.
// Reset: pipeline empties, registers return to 64 segments, step 6434,
//   edges -0.5 and +0.5.
// Stall: when the output register is held, the whole pipeline freezes and
//   in_ready drops; nothing is lost or repeated.
// ============================================================================
module mobius_strip_vertex_generator_unit #(
	parameter int MAX_SEGMENTS = msvg_pkg::MAX_SEGMENTS_DEF,
	parameter int CORDIC_STEPS = msvg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  msvg_pkg::reg_index_t cfg_index,
	input  logic [18:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [10:0]          segment_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   pos_x,
	output logic signed [15:0]   pos_y,
	output logic signed [15:0]   pos_z,
	output logic                 is_last,
	output logic                 range_error
);
	import msvg_pkg::*;

	logic [10:0]        seg_count_q;
	logic [18:0]        angle_step_q;
	logic signed [15:0] edge_low_q, edge_high_q;

	logic               adv;
	angle_t             ang;
	vert_t              vert;

	logic               cu_valid, ch_valid;
	logic signed [31:0] su, cu, sh, ch;
	logic [CORDIC_STEPS-1:0] err_line;

	logic               hold_v_q, phase_q, hold_err_q;
	logic signed [15:0] x_lo_q, y_lo_q, z_lo_q, x_hi_q, y_hi_q, z_hi_q;

	assign adv      = !hold_v_q || (out_ready && phase_q);
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= 11'd64;
			angle_step_q <= 19'd6434;
			edge_low_q   <= -16'sd16384;
			edge_high_q  <= 16'sd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEGMENT_COUNT: seg_count_q  <= cfg_data[10:0];
				REG_ANGLE_STEP:    angle_step_q <= cfg_data;
				REG_EDGE_LOW:      edge_low_q   <= cfg_data[15:0];
				REG_EDGE_HIGH:     edge_high_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	msvg_angle #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_angle (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.in_valid     (in_valid),
		.segment_index(segment_index),
		.segment_count(seg_count_q),
		.angle_step   (angle_step_q),
		.ang          (ang)
	);

	msvg_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (ang.valid),
		.angle    (ang.a_u),
		.neg_in   (ang.neg_u),
		.out_valid(cu_valid),
		.sin_out  (su),
		.cos_out  (cu)
	);

	msvg_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (ang.valid),
		.angle    (ang.a_h),
		.neg_in   (ang.neg_h),
		.out_valid(ch_valid),
		.sin_out  (sh),
		.cos_out  (ch)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			err_line <= {err_line[CORDIC_STEPS-2:0], ang.err};
		end
	end

	msvg_vertex u_vertex (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (cu_valid),
		.in_err   (err_line[CORDIC_STEPS-1]),
		.sin_u    (su),
		.cos_u    (cu),
		.sin_h    (sh),
		.cos_h    (ch),
		.edge_low (edge_low_q),
		.edge_high(edge_high_q),
		.vert     (vert)
	);

	function automatic logic signed [15:0] rnd42(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (p + 64'sd2199023255552) >>> 42;
		return sat16(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (adv) begin
				hold_v_q <= vert.valid;
			end
			if (out_valid && out_ready) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_err_q <= vert.err;
			x_lo_q     <= vert.err ? '0 : rnd42(vert.px_lo);
			y_lo_q     <= vert.err ? '0 : rnd42(vert.py_lo);
			z_lo_q     <= vert.err ? '0 : vert.z_lo;
			x_hi_q     <= vert.err ? '0 : rnd42(vert.px_hi);
			y_hi_q     <= vert.err ? '0 : rnd42(vert.py_hi);
			z_hi_q     <= vert.err ? '0 : vert.z_hi;
		end
	end

	assign out_valid   = hold_v_q;
	assign pos_x       = phase_q ? x_hi_q : x_lo_q;
	assign pos_y       = phase_q ? y_hi_q : y_lo_q;
	assign pos_z       = phase_q ? z_hi_q : z_lo_q;
	assign is_last     = phase_q;
	assign range_error = hold_err_q;

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		cu_valid == ch_valid)
		else $error("cordic lanes out of step");

	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> hold_v_q)
		else $error("second vertex phase without a held item");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && !(out_ready && phase_q)) |-> !in_ready)
		else $error("item taken while output register is held");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (pos_x == 16'sd0 && pos_y == 16'sd0 && pos_z == 16'sd0))
		else $error("range error item carries coordinates");

endmodule

// ----- rtl/core/msvg_angle.sv -----
// ============================================================================
// msvg_angle
// Front end: index check, angle product, reduction modulo 2*pi by reciprocal
// multiply, and folding into [-pi/2, pi/2] for both u and u/2.
// ============================================================================
module msvg_angle #(
	parameter int MAX_SEGMENTS = msvg_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [10:0]           segment_index,
	input  logic [10:0]           segment_count,
	input  logic [18:0]           angle_step,
	output msvg_pkg::angle_t      ang
);
	import msvg_pkg::*;

	localparam logic [21:0] RECIP = 22'((64'd1 << 52) / 64'(Q28_TWO_PI));
	localparam logic [31:0] TWO_PI_32 = 32'(Q28_TWO_PI);

	logic        err_in, eq_in, over_max;
	logic [31:0] k_wide, seg_wide;

	logic [6:0]  v_q;
	logic [6:0]  e_q;

	logic [10:0] k_s1;
	logic        eq_s1;
	logic [29:0] p_s2;
	logic [29:0] p_s3;
	logic [51:0] pm_s3;
	logic [29:0] p_s4;
	logic [42:0] tu_s4, th_s4;
	logic [31:0] ru_s5, rh_s5;
	logic [31:0] ru_s6, rh_s6;
	logic signed [31:0] au_s7, ah_s7;
	logic        nu_s7, nh_s7;

	logic signed [31:0] fu, fh;
	logic        fnu, fnh;

	assign k_wide   = 32'(segment_index);
	assign seg_wide = 32'(segment_count);
	assign over_max = seg_wide > 32'(MAX_SEGMENTS);
	assign err_in   = (k_wide > seg_wide) || (k_wide > 32'(MAX_SEGMENTS));
	assign eq_in    = over_max ? (k_wide == 32'(MAX_SEGMENTS)) : (k_wide == seg_wide);

	function automatic logic [32:0] fold(input logic [31:0] r);
		logic signed [31:0] a;
		logic               n;
		a = r;
		n = 1'b0;
		if (a > Q28_PI) begin
			a = a - $signed(TWO_PI_32);
		end
		if (a > Q28_HALF_PI) begin
			a = Q28_PI - a;
			n = 1'b1;
		end else if (a < -Q28_HALF_PI) begin
			a = -Q28_PI - a;
			n = 1'b1;
		end
		return {n, a};
	endfunction

	assign {fnu, fu} = fold(ru_s6);
	assign {fnh, fh} = fold(rh_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q   <= {e_q[5:0], err_in};
			k_s1  <= segment_index;
			eq_s1 <= eq_in;
			p_s2  <= eq_s1 ? Q16_TWO_PI : 30'(k_s1) * 30'(angle_step);
			p_s3  <= p_s2;
			pm_s3 <= 52'(p_s2) * 52'(RECIP);
			p_s4  <= p_s3;
			tu_s4 <= 43'(pm_s3[51:40]) * 43'(Q28_TWO_PI);
			th_s4 <= 43'(pm_s3[51:41]) * 43'(Q28_TWO_PI);
			ru_s5 <= 32'(43'({p_s4, 12'd0}) - tu_s4);
			rh_s5 <= 32'(43'({p_s4, 11'd0}) - th_s4);
			ru_s6 <= (ru_s5 >= TWO_PI_32) ? ru_s5 - TWO_PI_32 : ru_s5;
			rh_s6 <= (rh_s5 >= TWO_PI_32) ? rh_s5 - TWO_PI_32 : rh_s5;
			au_s7 <= fu;
			nu_s7 <= fnu;
			ah_s7 <= fh;
			nh_s7 <= fnh;
		end
	end

	assign ang.valid = v_q[6];
	assign ang.err   = e_q[6];
	assign ang.a_u   = au_s7;
	assign ang.neg_u = nu_s7;
	assign ang.a_h   = ah_s7;
	assign ang.neg_h = nh_s7;

endmodule

// ----- rtl/core/msvg_cordic.sv -----
// ============================================================================
// msvg_cordic
// Rotation-mode CORDIC, one register stage per iteration.
// ============================================================================
module msvg_cordic #(
	parameter int STEPS = msvg_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] angle,
	input  logic               neg_in,
	output logic               out_valid,
	output logic signed [31:0] sin_out,
	output logic signed [31:0] cos_out
);
	import msvg_pkg::*;

	logic signed [31:0] x_s [STEPS+1];
	logic signed [31:0] y_s [STEPS+1];
	logic signed [31:0] z_s [STEPS+1];
	logic               n_s [STEPS+1];
	logic [STEPS:0]     v_s;

	assign x_s[0] = Q28_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = angle;
	assign n_s[0] = neg_in;
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [31:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_q28(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_q28(5'(i));
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign sin_out   = y_s[STEPS];
	assign cos_out   = n_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];

endmodule

// ----- rtl/core/msvg_vertex.sv -----
// ============================================================================
// msvg_vertex
// Vertex arithmetic for both strip edges: radius, z and the x/y products.
// ============================================================================
module msvg_vertex (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               in_err,
	input  logic signed [31:0] sin_u,
	input  logic signed [31:0] cos_u,
	input  logic signed [31:0] sin_h,
	input  logic signed [31:0] cos_h,
	input  logic signed [15:0] edge_low,
	input  logic signed [15:0] edge_high,
	output msvg_pkg::vert_t    vert
);
	import msvg_pkg::*;

	logic [2:0] v_q;
	logic [2:0] e_q;

	logic signed [47:0] rp_lo_s1, rp_hi_s1, zp_lo_s1, zp_hi_s1;
	logic signed [31:0] su_s1, cu_s1, su_s2, cu_s2;
	logic signed [31:0] r_lo_s2, r_hi_s2;
	logic signed [15:0] z_lo_s2, z_hi_s2, z_lo_s3, z_hi_s3;
	logic signed [63:0] px_lo_s3, py_lo_s3, px_hi_s3, py_hi_s3;

	logic signed [47:0] rs_lo, rs_hi, zs_lo, zs_hi;

	assign rs_lo = (rp_lo_s1 + 48'sd16384) >>> 15;
	assign rs_hi = (rp_hi_s1 + 48'sd16384) >>> 15;
	assign zs_lo = (zp_lo_s1 + 48'sd268435456) >>> 29;
	assign zs_hi = (zp_hi_s1 + 48'sd268435456) >>> 29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q      <= {e_q[1:0], in_err};
			rp_lo_s1 <= 48'(edge_low) * 48'(cos_h);
			rp_hi_s1 <= 48'(edge_high) * 48'(cos_h);
			zp_lo_s1 <= 48'(edge_low) * 48'(sin_h);
			zp_hi_s1 <= 48'(edge_high) * 48'(sin_h);
			su_s1    <= sin_u;
			cu_s1    <= cos_u;
			r_lo_s2  <= 32'sd268435456 + rs_lo[31:0];
			r_hi_s2  <= 32'sd268435456 + rs_hi[31:0];
			z_lo_s2  <= sat16(64'(zs_lo));
			z_hi_s2  <= sat16(64'(zs_hi));
			su_s2    <= su_s1;
			cu_s2    <= cu_s1;
			px_lo_s3 <= 64'(r_lo_s2) * 64'(cu_s2);
			py_lo_s3 <= 64'(r_lo_s2) * 64'(su_s2);
			px_hi_s3 <= 64'(r_hi_s2) * 64'(cu_s2);
			py_hi_s3 <= 64'(r_hi_s2) * 64'(su_s2);
			z_lo_s3  <= z_lo_s2;
			z_hi_s3  <= z_hi_s2;
		end
	end

	assign vert.valid = v_q[2];
	assign vert.err   = e_q[2];
	assign vert.px_lo = px_lo_s3;
	assign vert.py_lo = py_lo_s3;
	assign vert.z_lo  = z_lo_s3;
	assign vert.px_hi = px_hi_s3;
	assign vert.py_hi = py_hi_s3;
	assign vert.z_hi  = z_hi_s3;

endmodule
